### rtl/core/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared widths, hash constants and handoff types for the value noise core.
// ----------------------------------------------------------------------------
package hvn_pkg;

    // field widths
    localparam int POS_BITS   = 32;
    localparam int CS_BITS    = 24;
    localparam int IDX_BITS   = 32;
    localparam int VALUE_BITS = 24;
    localparam int HASH_BITS  = 32;

    // reset value of the cell size register (256 m in Q16.8)
    localparam logic [CS_BITS-1:0] CELL_SIZE_RESET = 24'd65536;

    // default depth of the split-to-blend queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // corner hash constants
    localparam logic [HASH_BITS-1:0] SEED_EAST  = 32'h8da6b343;
    localparam logic [HASH_BITS-1:0] SEED_NORTH = 32'hd8163841;
    localparam logic [HASH_BITS-1:0] MIX_ONE    = 32'h2c1b3c6d;
    localparam logic [HASH_BITS-1:0] MIX_TWO    = 32'h297a2d39;
    localparam int HASH_SHIFT_WIDE   = 15;
    localparam int HASH_SHIFT_NARROW = 12;

    // one split sample: cell indices and shaped fractions
    typedef struct packed {
        logic [IDX_BITS-1:0]   idx_e;
        logic [IDX_BITS-1:0]   idx_n;
        logic [VALUE_BITS-1:0] s_e;
        logic [VALUE_BITS-1:0] s_n;
    } t_split;

    // queue status toward the top level
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

### rtl/core/hvn_coord_split.sv
// ----------------------------------------------------------------------------
// hvn_coord_split
// Pipelined floor division of one coordinate by the cell size, fraction
// extraction and smoothstep shaping. One bit of quotient per stage.
// ----------------------------------------------------------------------------
module hvn_coord_split
    import hvn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [POS_BITS-1:0]   i_pos,
    input  logic [CS_BITS-1:0]    i_cell_size,
    output logic                  o_valid,
    output logic [IDX_BITS-1:0]   o_idx,
    output logic [VALUE_BITS-1:0] o_shaped
);

    localparam int QSTAGES = POS_BITS;
    localparam int FSTAGES = VALUE_BITS;

    // quotient pipeline: word holds remaining dividend bits on top, quotient below
    logic                r_qv   [0:QSTAGES];
    logic                r_qneg [0:QSTAGES];
    logic [POS_BITS-1:0] r_qw   [0:QSTAGES];
    logic [CS_BITS-1:0]  r_qrem [0:QSTAGES];

    logic [CS_BITS:0]    q_trial [0:QSTAGES-1];
    logic                q_fit   [0:QSTAGES-1];

    // fraction pipeline
    logic                  r_pv   [0:FSTAGES];
    logic [IDX_BITS-1:0]   r_pidx [0:FSTAGES];
    logic [CS_BITS-1:0]    r_prem [0:FSTAGES];
    logic [VALUE_BITS-1:0] r_pu   [0:FSTAGES];

    logic [CS_BITS:0]      p_trial [0:FSTAGES-1];
    logic                  p_fit   [0:FSTAGES-1];

    // fixup of the signed floor
    logic [IDX_BITS-1:0] fix_idx;
    logic [CS_BITS-1:0]  fix_rem;

    // smoothstep stages
    logic                    r_sv1, r_sv2;
    logic [IDX_BITS-1:0]     r_sidx1, r_sidx2;
    logic [VALUE_BITS-1:0]   r_u2;
    logic [VALUE_BITS+1:0]   r_t;
    logic [VALUE_BITS-1:0]   r_s;
    logic [2*VALUE_BITS-1:0] sq;
    logic [2*VALUE_BITS+1:0] sp;

    // restoring division steps
    always_comb begin
        for (int k = 0; k < QSTAGES; k++) begin
            q_trial[k] = {r_qrem[k], r_qw[k][POS_BITS-1]};
            q_fit[k]   = (q_trial[k] >= {1'b0, i_cell_size});
        end
        for (int k = 0; k < FSTAGES; k++) begin
            p_trial[k] = {r_prem[k], 1'b0};
            p_fit[k]   = (p_trial[k] >= {1'b0, i_cell_size});
        end
    end

    // negative positions: negate the index; if a remainder is left, step it down and mirror it
    always_comb begin
        fix_idx = r_qw[QSTAGES];
        fix_rem = r_qrem[QSTAGES];
        if (r_qneg[QSTAGES]) begin
            if (r_qrem[QSTAGES] == '0) begin
                fix_idx = IDX_BITS'(~r_qw[QSTAGES] + 1'b1);
            end else begin
                fix_idx = ~r_qw[QSTAGES];
                fix_rem = i_cell_size - r_qrem[QSTAGES];
            end
        end
    end

    // smoothstep products
    assign sq = {{VALUE_BITS{1'b0}}, r_pu[FSTAGES]} * {{VALUE_BITS{1'b0}}, r_pu[FSTAGES]};
    assign sp = {{(VALUE_BITS+2){1'b0}}, r_u2} * {{VALUE_BITS{1'b0}}, r_t};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QSTAGES; k++) r_qv[k] <= 1'b0;
            for (int k = 0; k <= FSTAGES; k++) r_pv[k] <= 1'b0;
            r_sv1 <= 1'b0;
            r_sv2 <= 1'b0;
        end else begin
            r_qv[0] <= i_valid;
            for (int k = 0; k < QSTAGES; k++) r_qv[k+1] <= r_qv[k];
            r_pv[0] <= r_qv[QSTAGES];
            for (int k = 0; k < FSTAGES; k++) r_pv[k+1] <= r_pv[k];
            r_sv1 <= r_pv[FSTAGES];
            r_sv2 <= r_sv1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_qneg[0] <= i_pos[POS_BITS-1];
        r_qw[0]   <= i_pos[POS_BITS-1] ? POS_BITS'(~i_pos + 1'b1) : i_pos;
        r_qrem[0] <= '0;
        for (int k = 0; k < QSTAGES; k++) begin
            r_qneg[k+1] <= r_qneg[k];
            r_qw[k+1]   <= {r_qw[k][POS_BITS-2:0], q_fit[k]};
            r_qrem[k+1] <= q_fit[k] ? CS_BITS'(q_trial[k] - {1'b0, i_cell_size})
                                    : q_trial[k][CS_BITS-1:0];
        end
        r_pidx[0] <= fix_idx;
        r_prem[0] <= fix_rem;
        r_pu[0]   <= '0;
        for (int k = 0; k < FSTAGES; k++) begin
            r_pidx[k+1] <= r_pidx[k];
            r_pu[k+1]   <= {r_pu[k][VALUE_BITS-2:0], p_fit[k]};
            r_prem[k+1] <= p_fit[k] ? CS_BITS'(p_trial[k] - {1'b0, i_cell_size})
                                    : p_trial[k][CS_BITS-1:0];
        end
        r_sidx1 <= r_pidx[FSTAGES];
        r_u2    <= sq[2*VALUE_BITS-1:VALUE_BITS];
        r_t     <= ((VALUE_BITS+2)'(3) << VALUE_BITS) - {1'b0, r_pu[FSTAGES], 1'b0};
        r_sidx2 <= r_sidx1;
        r_s     <= sp[2*VALUE_BITS-1:VALUE_BITS];
    end

    assign o_valid  = r_sv2;
    assign o_idx    = r_sidx2;
    assign o_shaped = r_s;

endmodule

### rtl/core/hvn_queue.sv
// ----------------------------------------------------------------------------
// hvn_queue
// Short FIFO between the coordinate split front and the corner blend back.
// ----------------------------------------------------------------------------
module hvn_queue
    import hvn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_split        i_data,
    input  logic          i_pop,
    output t_split        o_data,
    output t_queue_status o_status
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_split              r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign do_push = i_push && (r_count != CNT_BITS'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_BITS'(DEPTH));

endmodule

### rtl/core/hvn_corner_blend.sv
// ----------------------------------------------------------------------------
// hvn_corner_blend
// Hashes the four cell corners and blends them bilinearly, east then north.
// ----------------------------------------------------------------------------
module hvn_corner_blend
    import hvn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_split                i_split,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam int STAGES = 10;

    logic [STAGES-1:0] r_vld;

    // seed products
    logic [HASH_BITS-1:0] r1_ie, r1_ie1, r1_je, r1_je1;
    logic [VALUE_BITS-1:0] r1_se, r1_sn;
    // mix rounds
    logic [HASH_BITS-1:0] h2 [4];
    logic [HASH_BITS-1:0] r2_h [4];
    logic [HASH_BITS-1:0] r3_h [4];
    logic [VALUE_BITS-1:0] r4_v [4];
    logic [VALUE_BITS-1:0] r2_se, r3_se, r4_se, r5_se, r2_sn, r3_sn, r4_sn, r5_sn;
    logic [VALUE_BITS-1:0] r6_sn, r7_sn, r8_sn;
    // first blend
    logic                  r5_ge_lo, r5_ge_hi, r6_ge_lo, r6_ge_hi;
    logic [VALUE_BITS-1:0] r5_dlo, r5_dhi, r5_alo, r5_ahi, r6_alo, r6_ahi;
    logic [VALUE_BITS-1:0] r6_plo, r6_phi, r7_lo, r7_hi;
    logic [2*VALUE_BITS-1:0] plo, phi;
    // second blend
    logic                  r8_ge, r9_ge;
    logic [VALUE_BITS-1:0] r8_d, r8_a, r9_a, r9_p, r10_out;
    logic [2*VALUE_BITS-1:0] pout;

    // first mix round inputs: corners a, b, c, d
    always_comb begin
        h2[0] = r1_ie  ^ r1_je;
        h2[1] = r1_ie1 ^ r1_je;
        h2[2] = r1_ie  ^ r1_je1;
        h2[3] = r1_ie1 ^ r1_je1;
        for (int k = 0; k < 4; k++) begin
            h2[k] = h2[k] ^ (h2[k] >> HASH_SHIFT_WIDE);
        end
    end

    assign plo  = {{VALUE_BITS{1'b0}}, r5_dlo} * {{VALUE_BITS{1'b0}}, r5_se};
    assign phi  = {{VALUE_BITS{1'b0}}, r5_dhi} * {{VALUE_BITS{1'b0}}, r5_se};
    assign pout = {{VALUE_BITS{1'b0}}, r8_d} * {{VALUE_BITS{1'b0}}, r8_sn};

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // seeds; index plus one wraps
        r1_ie  <= i_split.idx_e * SEED_EAST;
        r1_ie1 <= IDX_BITS'(i_split.idx_e + 1'b1) * SEED_EAST;
        r1_je  <= i_split.idx_n * SEED_NORTH;
        r1_je1 <= IDX_BITS'(i_split.idx_n + 1'b1) * SEED_NORTH;
        r1_se  <= i_split.s_e;
        r1_sn  <= i_split.s_n;
        // mix rounds
        for (int k = 0; k < 4; k++) begin
            r2_h[k] <= h2[k] * MIX_ONE;
            r3_h[k] <= (r2_h[k] ^ (r2_h[k] >> HASH_SHIFT_NARROW)) * MIX_TWO;
            r4_v[k] <= VALUE_BITS'(r3_h[k] ^ (r3_h[k] >> HASH_SHIFT_WIDE));
        end
        r2_se <= r1_se; r3_se <= r2_se; r4_se <= r3_se; r5_se <= r4_se;
        r2_sn <= r1_sn; r3_sn <= r2_sn; r4_sn <= r3_sn; r5_sn <= r4_sn;
        r6_sn <= r5_sn; r7_sn <= r6_sn; r8_sn <= r7_sn;
        // east blend: distance and direction
        r5_ge_lo <= (r4_v[1] >= r4_v[0]);
        r5_dlo   <= (r4_v[1] >= r4_v[0]) ? r4_v[1] - r4_v[0] : r4_v[0] - r4_v[1];
        r5_alo   <= r4_v[0];
        r5_ge_hi <= (r4_v[3] >= r4_v[2]);
        r5_dhi   <= (r4_v[3] >= r4_v[2]) ? r4_v[3] - r4_v[2] : r4_v[2] - r4_v[3];
        r5_ahi   <= r4_v[2];
        // east blend: scaled step, truncated
        r6_plo   <= plo[2*VALUE_BITS-1:VALUE_BITS];
        r6_phi   <= phi[2*VALUE_BITS-1:VALUE_BITS];
        r6_ge_lo <= r5_ge_lo;
        r6_ge_hi <= r5_ge_hi;
        r6_alo   <= r5_alo;
        r6_ahi   <= r5_ahi;
        r7_lo    <= r6_ge_lo ? r6_alo + r6_plo : r6_alo - r6_plo;
        r7_hi    <= r6_ge_hi ? r6_ahi + r6_phi : r6_ahi - r6_phi;
        // north blend
        r8_ge    <= (r7_hi >= r7_lo);
        r8_d     <= (r7_hi >= r7_lo) ? r7_hi - r7_lo : r7_lo - r7_hi;
        r8_a     <= r7_lo;
        r9_p     <= pout[2*VALUE_BITS-1:VALUE_BITS];
        r9_ge    <= r8_ge;
        r9_a     <= r8_a;
        r10_out  <= r9_ge ? r9_a + r9_p : r9_a - r9_p;
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_value = r10_out;

endmodule

### rtl/core/hashed_value_noise_2d.sv
// ----------------------------------------------------------------------------
// hashed_value_noise_2d
// 2D value noise sampler: floor division into cells, smoothstep, corner
// hashing and bilinear blend.
// ----------------------------------------------------------------------------
// Path: coordinate divide/smoothstep pipe, then the queue, then the blend.
// Throughput: one beat per cycle while busy is low; the one-bit-per-stage dividers
//   are fully pipelined and the blend stage pops the queue whenever it holds a beat.
// Reset: synchronous active-low; clears all valid flags and the queue and
//   loads the cell size with 65536 (256 m). The receiver cannot stall.
module hashed_value_noise_2d
    import hvn_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [POS_BITS-1:0]   i_east_pos,
    input  logic [POS_BITS-1:0]   i_north_pos,
    input  logic                  i_cfg_we,
    input  logic [CS_BITS-1:0]    i_cfg_wdata,
    output logic                  o_valid,
    output logic [VALUE_BITS-1:0] o_noise_value
);

    logic [CS_BITS-1:0]    r_cell_size;
    logic [CS_BITS-1:0]    cs_eff;
    logic                  in_beat;
    logic                  east_vld, north_vld, front_vld;
    logic [IDX_BITS-1:0]   east_idx, north_idx;
    logic [VALUE_BITS-1:0] east_s, north_s;
    t_split                front_split, back_split;
    t_queue_status         q_status;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CELL_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_cell_size <= i_cfg_wdata;
        end
    end

    // zero cell size acts as one
    assign cs_eff  = (r_cell_size == '0) ? CS_BITS'(1) : r_cell_size;
    assign in_beat = start && !busy;

    // front: per-axis split
    hvn_coord_split u_split_e (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_beat),
        .i_pos       (i_east_pos),
        .i_cell_size (cs_eff),
        .o_valid     (east_vld),
        .o_idx       (east_idx),
        .o_shaped    (east_s)
    );

    hvn_coord_split u_split_n (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_beat),
        .i_pos       (i_north_pos),
        .i_cell_size (cs_eff),
        .o_valid     (north_vld),
        .o_idx       (north_idx),
        .o_shaped    (north_s)
    );

    assign front_vld         = east_vld && north_vld;
    assign front_split.idx_e = east_idx;
    assign front_split.idx_n = north_idx;
    assign front_split.s_e   = east_s;
    assign front_split.s_n   = north_s;

    // queue between front and back; back pops whenever a beat is waiting
    hvn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_vld),
        .i_data   (front_split),
        .i_pop    (!q_status.empty),
        .o_data   (back_split),
        .o_status (q_status)
    );

    // back: hash and blend
    hvn_corner_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_status.empty),
        .i_split (back_split),
        .o_valid (o_valid),
        .o_value (o_noise_value)
    );

    assign busy = q_status.full;

    // both axis pipes stay in lockstep
    a_axis_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        east_vld == north_vld)
        else $error("axis split pipes out of step");

    // no beat is dropped into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(front_vld && q_status.full))
        else $error("queue overflow");

    // a pushed beat into an empty queue is visible next cycle
    a_push_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_vld && q_status.empty) |=> !q_status.empty)
        else $error("pushed beat lost");

endmodule
